FILE: rtl/sgr_projection_solver_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the projection solver
// Concurrent checks that fall away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SGR_PROJECTION_SOLVER_TOP_ASSERT_SVH
`define SGR_PROJECTION_SOLVER_TOP_ASSERT_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define SGR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgr assertion failed");
// antecedent implies consequent in the next cycle
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgr assertion failed");
`else
`define SGR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// sgr_pkg
// Shared constants, command and status types of the projection solver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sgr_pkg;

   // algorithm constants
   localparam int SAMPLE_BITS     = 12;
   localparam int RST_SHIFT       = 4;
   localparam int PRJ_SHIFT       = 7;
   localparam int MAX_PIXELS_LOG2 = 16;

   // field and datapath widths
   localparam int SAMPLE_W = 12;
   localparam int FILT_W   = 18;
   localparam int WEIGHT_W = 32;
   localparam int SUM_W    = 64;
   localparam int HALF_W   = 32;
   localparam int MUL_W    = 2 * HALF_W;
   localparam int WIDE_W   = 2 * SUM_W;
   localparam int COUNT_W  = MAX_PIXELS_LOG2 + 1;
   localparam int BOUND_W  = 2 * COUNT_W;
   localparam int BASE_W   = SAMPLE_BITS + RST_SHIFT;
   localparam int ERR_W    = BASE_W + 1;
   localparam int DIFF_W   = ((BASE_W + 1 > FILT_W) ? BASE_W + 1 : FILT_W) + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int STEP_W   = $clog2(WIDE_W);

   // ill-posed threshold scale (reciprocal of 1e-8)
   localparam logic [HALF_W-1:0] ILL_SCALE = 32'd100000000;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER0_EN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER1_EN = 2'd1;

   // datapath operations
   typedef enum logic [3:0] {
      DP_NOP,
      DP_BOUND,
      DP_SCALAR,
      DP_PLOAD,
      DP_PMUL,
      DP_PADD,
      DP_COMMIT,
      DP_SCALE,
      DP_TEST,
      DP_DLOAD,
      DP_DSTEP,
      DP_ROUND,
      DP_INC,
      DP_SAT,
      DP_EMIT
   } dp_op_type;

   // controller to datapath
   typedef struct packed {
      logic      pix_accept;
      dp_op_type op;
      logic [2:0] job;
      logic [1:0] part;
      logic      sel;
   } sgr_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ill_posed;
      logic full_solve;
   } sgr_status_type;

endpackage

FILE: rtl/sgr_if.sv
// ----------------------------------------------------------------------------
// sgr channel interfaces
// Valid/ready channels for pixels, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sgr_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [sgr_pkg::SAMPLE_W-1:0]         source_sample;
   logic [sgr_pkg::SAMPLE_W-1:0]         degraded_sample;
   logic signed [sgr_pkg::FILT_W-1:0]    filter0_value;
   logic signed [sgr_pkg::FILT_W-1:0]    filter1_value;
   logic                                 last_pixel;

   modport source (output valid, source_sample, degraded_sample, filter0_value,
                   filter1_value, last_pixel, input ready);
   modport sink (input valid, source_sample, degraded_sample, filter0_value,
                 filter1_value, last_pixel, output ready);
endinterface

interface sgr_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [sgr_pkg::WEIGHT_W-1:0]  weight0;
   logic signed [sgr_pkg::WEIGHT_W-1:0]  weight1;
   logic                                 ill_posed;

   modport source (output valid, weight0, weight1, ill_posed, input ready);
   modport sink (input valid, weight0, weight1, ill_posed, output ready);
endinterface

interface sgr_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [sgr_pkg::CSR_IDX_W-1:0]        index;
   logic                                 data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/sgr_projection_solver_top.sv
// ----------------------------------------------------------------------------
// sgr_projection_solver_top
// Least-squares projection weights for self-guided restoration.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock while the block is collecting a unit; the
// five products go through a two-stage multiply and accumulate pipe. After a
// transaction marked last_pixel the intake closes and the solve runs on one
// shared 32x32 multiplier and a one-bit-per-cycle restoring divider of 128
// bits. The two-filter solve runs six 64x64 products in four partial products
// each, then two 128-step divisions; the one-filter form has no products and
// an ill-posed system skips the divisions. The result sits in an output
// register; the next unit is accepted once it has been loaded.
`timescale 1ns / 1ps

module sgr_projection_solver_top (
   input logic       clock,
   input logic       reset,
   sgr_req_if.sink   req_if,
   sgr_rsp_if.source rsp_if,
   sgr_csr_if.sink   csr_if
);
   import sgr_pkg::*;

   logic           filter0_en_ff, filter1_en_ff;
   sgr_cmd_type    cmd;
   sgr_status_type status;

   // configuration registers
   assign csr_if.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         filter0_en_ff <= 1'b1;
         filter1_en_ff <= 1'b1;
      end else if (csr_if.valid) begin
         if (csr_if.index == CSR_FILTER0_EN)
            filter0_en_ff <= csr_if.data;
         if (csr_if.index == CSR_FILTER1_EN)
            filter1_en_ff <= csr_if.data;
      end
   end

   // sequencer
   sgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_pixel),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic
   sgr_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .filter0_enabled (filter0_en_ff),
      .filter1_enabled (filter1_en_ff),
      .cmd             (cmd),
      .status          (status),
      .source_sample   (req_if.source_sample),
      .degraded_sample (req_if.degraded_sample),
      .filter0_value   (req_if.filter0_value),
      .filter1_value   (req_if.filter1_value),
      .weight0         (rsp_if.weight0),
      .weight1         (rsp_if.weight1),
      .ill_posed       (rsp_if.ill_posed)
   );

endmodule

FILE: rtl/sgr_dpath.sv
// ----------------------------------------------------------------------------
// sgr_dpath
// Pixel accumulation pipeline, shared 32x32 multiplier, wide solve registers,
// restoring divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sgr_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                filter0_enabled,
   input  logic                                filter1_enabled,
   input  sgr_pkg::sgr_cmd_type                cmd,
   output sgr_pkg::sgr_status_type             status,
   input  logic [sgr_pkg::SAMPLE_W-1:0]        source_sample,
   input  logic [sgr_pkg::SAMPLE_W-1:0]        degraded_sample,
   input  logic signed [sgr_pkg::FILT_W-1:0]   filter0_value,
   input  logic signed [sgr_pkg::FILT_W-1:0]   filter1_value,
   output logic signed [sgr_pkg::WEIGHT_W-1:0] weight0,
   output logic signed [sgr_pkg::WEIGHT_W-1:0] weight1,
   output logic                                ill_posed
);
   import sgr_pkg::*;

   // pixel stage 1: differences
   logic [BASE_W-1:0]        base_c, src_c;
   logic signed [ERR_W-1:0]  err_c;
   logic signed [DIFF_W-1:0] d0_c, d1_c;
   logic signed [DIFF_W-1:0] d0_ff, d1_ff;
   logic signed [ERR_W-1:0]  err_ff;
   logic                     s1_valid_ff;

   // pixel stage 2: products
   logic signed [PROD_W-1:0] p00_ff, p11_ff, p01_ff, p0e_ff, p1e_ff;
   logic                     s2_valid_ff;

   // accumulators
   logic signed [SUM_W-1:0]  sum_f0_sq_ff, sum_f1_sq_ff, sum_f0_f1_ff;
   logic signed [SUM_W-1:0]  sum_f0_err_ff, sum_f1_err_ff;
   logic [COUNT_W-1:0]       count_ff;

   // solve registers
   logic [SUM_W-1:0]         ma_ff, mb_ff;
   logic                     pneg_ff;
   logic [WIDE_W-1:0]        pacc_ff;
   logic [MUL_W-1:0]         prod_ff;
   logic [BOUND_W-1:0]       bound_ff;
   logic [WIDE_W-1:0]        det_ff, num0_ff, num1_ff;
   logic                     ill_ff;
   logic [WIDE_W-1:0]        mag_ff, rem_ff, q_ff;
   logic                     dneg_ff, rnd_ff;
   logic [WEIGHT_W-1:0]      w0_ff, w1_ff;
   logic [WEIGHT_W-1:0]      weight0_ff, weight1_ff;
   logic                     ill_out_ff;

   // combinational helpers
   logic signed [SUM_W-1:0]  pa_c, pb_c;
   logic [HALF_W-1:0]        mul_a, mul_b;
   logic [MUL_W-1:0]         mul_c;
   logic [1:0]               part_sum;
   logic [WIDE_W-1:0]        tgt_c, tgt_old, tgt_new;
   logic                     tsub;
   logic [WIDE_W-1:0]        dsrc;
   logic [WIDE_W-1:0]        rem_sh, two_rem;
   logic [WIDE_W:0]          diff_c;
   logic [WEIGHT_W-1:0]      sat_c;

   // differences of the incoming pixel
   assign base_c = BASE_W'(degraded_sample[SAMPLE_BITS-1:0]) << RST_SHIFT;
   assign src_c  = BASE_W'(source_sample[SAMPLE_BITS-1:0]) << RST_SHIFT;
   assign err_c  = $signed({1'b0, src_c}) - $signed({1'b0, base_c});
   assign d0_c   = filter0_enabled ?
                   DIFF_W'(filter0_value) - DIFF_W'($signed({1'b0, base_c})) : '0;
   assign d1_c   = filter1_enabled ?
                   DIFF_W'(filter1_value) - DIFF_W'($signed({1'b0, base_c})) : '0;

   // pixel pipeline and accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         sum_f0_sq_ff  <= '0;
         sum_f1_sq_ff  <= '0;
         sum_f0_f1_ff  <= '0;
         sum_f0_err_ff <= '0;
         sum_f1_err_ff <= '0;
         count_ff      <= '0;
      end else begin
         s1_valid_ff <= cmd.pix_accept;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.op == DP_EMIT) begin
            sum_f0_sq_ff  <= '0;
            sum_f1_sq_ff  <= '0;
            sum_f0_f1_ff  <= '0;
            sum_f0_err_ff <= '0;
            sum_f1_err_ff <= '0;
            count_ff      <= '0;
         end else if (s2_valid_ff && !count_ff[COUNT_W-1]) begin
            sum_f0_sq_ff  <= sum_f0_sq_ff + SUM_W'(p00_ff);
            sum_f1_sq_ff  <= sum_f1_sq_ff + SUM_W'(p11_ff);
            sum_f0_f1_ff  <= sum_f0_f1_ff + SUM_W'(p01_ff);
            sum_f0_err_ff <= sum_f0_err_ff + SUM_W'(p0e_ff);
            sum_f1_err_ff <= sum_f1_err_ff + SUM_W'(p1e_ff);
            count_ff      <= count_ff + COUNT_W'(1);
         end
      end
   end

   // pixel payload stages
   always_ff @(posedge clock) begin
      if (cmd.pix_accept) begin
         d0_ff  <= d0_c;
         d1_ff  <= d1_c;
         err_ff <= err_c;
      end
      p00_ff <= PROD_W'(d0_ff) * PROD_W'(d0_ff);
      p11_ff <= PROD_W'(d1_ff) * PROD_W'(d1_ff);
      p01_ff <= PROD_W'(d0_ff) * PROD_W'(d1_ff);
      p0e_ff <= PROD_W'(d0_ff) * PROD_W'(err_ff);
      p1e_ff <= PROD_W'(d1_ff) * PROD_W'(err_ff);
   end

   // operand pair of each product job
   always_comb begin
      case (cmd.job)
         3'd0:    begin pa_c = sum_f0_sq_ff; pb_c = sum_f1_sq_ff;  end
         3'd1:    begin pa_c = sum_f0_f1_ff; pb_c = sum_f0_f1_ff;  end
         3'd2:    begin pa_c = sum_f1_sq_ff; pb_c = sum_f0_err_ff; end
         3'd3:    begin pa_c = sum_f0_f1_ff; pb_c = sum_f1_err_ff; end
         3'd4:    begin pa_c = sum_f0_sq_ff; pb_c = sum_f1_err_ff; end
         3'd5:    begin pa_c = sum_f0_f1_ff; pb_c = sum_f0_err_ff; end
         default: begin pa_c = '0;           pb_c = '0;            end
      endcase
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.op)
         DP_BOUND: begin
            mul_a = HALF_W'(count_ff);
            mul_b = status.full_solve ? HALF_W'(count_ff) : HALF_W'(1);
         end
         DP_SCALE: begin
            mul_a = det_ff[HALF_W-1:0];
            mul_b = ILL_SCALE;
         end
         DP_PMUL: begin
            mul_a = cmd.part[1] ? ma_ff[SUM_W-1:HALF_W] : ma_ff[HALF_W-1:0];
            mul_b = cmd.part[0] ? mb_ff[SUM_W-1:HALF_W] : mb_ff[HALF_W-1:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_c = MUL_W'(mul_a) * MUL_W'(mul_b);

   // wide target of a commit
   assign part_sum = {1'b0, cmd.part[1]} + {1'b0, cmd.part[0]};
   always_comb begin
      case (cmd.job[2:1])
         2'd0:    tgt_c = det_ff;
         2'd1:    tgt_c = num0_ff;
         default: tgt_c = num1_ff;
      endcase
   end
   assign tgt_old = cmd.job[0] ? tgt_c : '0;
   assign tsub    = pneg_ff ^ cmd.job[0];
   assign tgt_new = tsub ? tgt_old - pacc_ff : tgt_old + pacc_ff;

   // divider step and rounding helpers
   assign dsrc    = cmd.sel ? num1_ff : num0_ff;
   assign rem_sh  = {rem_ff[WIDE_W-2:0], mag_ff[WIDE_W-1]};
   assign diff_c  = {1'b0, rem_sh} - {1'b0, det_ff};
   assign two_rem = {rem_ff[WIDE_W-2:0], 1'b0};

   // saturation to 32 bits
   always_comb begin
      if (!dneg_ff) begin
         if (|q_ff[WIDE_W-1:WEIGHT_W-1])
            sat_c = {1'b0, {(WEIGHT_W-1){1'b1}}};
         else
            sat_c = q_ff[WEIGHT_W-1:0];
      end else begin
         if ((|q_ff[WIDE_W-1:WEIGHT_W]) ||
             (q_ff[WEIGHT_W-1] && (|q_ff[WEIGHT_W-2:0])))
            sat_c = {1'b1, {(WEIGHT_W-1){1'b0}}};
         else
            sat_c = '0 - q_ff[WEIGHT_W-1:0];
      end
   end

   // solve sequence registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ill_ff <= 1'b0;
      end else begin
         case (cmd.op)
            DP_BOUND: begin
               bound_ff <= mul_c[BOUND_W-1:0];
            end
            DP_SCALAR: begin
               det_ff  <= filter0_enabled ? WIDE_W'(sum_f0_sq_ff) : WIDE_W'(sum_f1_sq_ff);
               num0_ff <= filter0_enabled ? WIDE_W'(sum_f0_err_ff) : '0;
               num1_ff <= filter0_enabled ? '0 : WIDE_W'(sum_f1_err_ff);
            end
            DP_PLOAD: begin
               ma_ff   <= pa_c[SUM_W-1] ? '0 - $unsigned(pa_c) : $unsigned(pa_c);
               mb_ff   <= pb_c[SUM_W-1] ? '0 - $unsigned(pb_c) : $unsigned(pb_c);
               pneg_ff <= pa_c[SUM_W-1] ^ pb_c[SUM_W-1];
               pacc_ff <= '0;
            end
            DP_PMUL: begin
               prod_ff <= mul_c;
            end
            DP_PADD: begin
               pacc_ff <= pacc_ff + (WIDE_W'(prod_ff) << (HALF_W * int'(part_sum)));
            end
            DP_COMMIT: begin
               case (cmd.job[2:1])
                  2'd0:    det_ff  <= tgt_new;
                  2'd1:    num0_ff <= tgt_new;
                  default: num1_ff <= tgt_new;
               endcase
            end
            DP_SCALE: begin
               prod_ff <= mul_c;
            end
            DP_TEST: begin
               ill_ff <= det_ff[WIDE_W-1] ||
                         (!(|det_ff[WIDE_W-2:HALF_W]) && (prod_ff < MUL_W'(bound_ff)));
               w0_ff  <= '0;
               w1_ff  <= '0;
            end
            DP_DLOAD: begin
               dneg_ff <= dsrc[WIDE_W-1];
               mag_ff  <= (dsrc[WIDE_W-1] ? '0 - dsrc : dsrc) << PRJ_SHIFT;
               rem_ff  <= '0;
               q_ff    <= '0;
            end
            DP_DSTEP: begin
               mag_ff <= {mag_ff[WIDE_W-2:0], 1'b0};
               if (!diff_c[WIDE_W]) begin
                  rem_ff <= diff_c[WIDE_W-1:0];
                  q_ff   <= {q_ff[WIDE_W-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  q_ff   <= {q_ff[WIDE_W-2:0], 1'b0};
               end
            end
            DP_ROUND: begin
               rnd_ff <= (two_rem >= det_ff) && ((two_rem != det_ff) || q_ff[0]);
            end
            DP_INC: begin
               q_ff <= q_ff + WIDE_W'(rnd_ff);
            end
            DP_SAT: begin
               if (cmd.sel)
                  w1_ff <= sat_c;
               else
                  w0_ff <= sat_c;
            end
            default: begin
            end
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.op == DP_EMIT) begin
         weight0_ff <= w0_ff;
         weight1_ff <= w1_ff;
         ill_out_ff <= ill_ff;
      end
   end

   assign weight0           = $signed(weight0_ff);
   assign weight1           = $signed(weight1_ff);
   assign ill_posed         = ill_out_ff;
   assign status.ill_posed  = ill_ff;
   assign status.full_solve = filter0_enabled & filter1_enabled;

endmodule

FILE: rtl/sgr_ctrl.sv
// ----------------------------------------------------------------------------
// sgr_ctrl
// Sequencer: pixel acceptance, product jobs, ill-posed test, two divisions
// and the result handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sgr_projection_solver_top_assert.svh"

module sgr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  sgr_pkg::sgr_status_type status,
   output sgr_pkg::sgr_cmd_type    cmd
);
   import sgr_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DRAIN_A,
      ST_DRAIN_B,
      ST_BOUND,
      ST_SCALAR,
      ST_PLOAD,
      ST_PMUL,
      ST_PADD,
      ST_COMMIT,
      ST_SCALE,
      ST_TEST,
      ST_CHECK,
      ST_DLOAD,
      ST_DSTEP,
      ST_ROUND,
      ST_INC,
      ST_SAT,
      ST_EMIT
   } state_type;

   localparam logic [2:0]        LAST_JOB = 3'd5;
   localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(WIDE_W - 1);

   state_type         state_ff, state_in;
   logic [2:0]        job_ff, job_in;
   logic [1:0]        part_ff, part_in;
   logic              sel_ff, sel_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      job_in         = job_ff;
      part_in        = part_ff;
      sel_in         = sel_ff;
      step_in        = step_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      cmd.pix_accept = accept;
      cmd.op         = DP_NOP;
      cmd.job        = job_ff;
      cmd.part       = part_ff;
      cmd.sel        = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last)
               state_in = ST_DRAIN_A;
         end
         ST_DRAIN_A: state_in = ST_DRAIN_B;
         ST_DRAIN_B: state_in = ST_BOUND;
         ST_BOUND: begin
            cmd.op = DP_BOUND;
            job_in = '0;
            state_in = status.full_solve ? ST_PLOAD : ST_SCALAR;
         end
         ST_SCALAR: begin
            cmd.op   = DP_SCALAR;
            state_in = ST_SCALE;
         end
         ST_PLOAD: begin
            cmd.op   = DP_PLOAD;
            part_in  = '0;
            state_in = ST_PMUL;
         end
         ST_PMUL: begin
            cmd.op   = DP_PMUL;
            state_in = ST_PADD;
         end
         ST_PADD: begin
            cmd.op  = DP_PADD;
            part_in = part_ff + 2'd1;
            state_in = (part_ff == 2'd3) ? ST_COMMIT : ST_PMUL;
         end
         ST_COMMIT: begin
            cmd.op = DP_COMMIT;
            job_in = job_ff + 3'd1;
            state_in = (job_ff == LAST_JOB) ? ST_SCALE : ST_PLOAD;
         end
         ST_SCALE: begin
            cmd.op   = DP_SCALE;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            cmd.op   = DP_TEST;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            sel_in   = 1'b0;
            state_in = status.ill_posed ? ST_EMIT : ST_DLOAD;
         end
         ST_DLOAD: begin
            cmd.op   = DP_DLOAD;
            step_in  = '0;
            state_in = ST_DSTEP;
         end
         ST_DSTEP: begin
            cmd.op  = DP_DSTEP;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_MAX)
               state_in = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.op   = DP_ROUND;
            state_in = ST_INC;
         end
         ST_INC: begin
            cmd.op   = DP_INC;
            state_in = ST_SAT;
         end
         ST_SAT: begin
            cmd.op = DP_SAT;
            sel_in = 1'b1;
            state_in = sel_ff ? ST_EMIT : ST_DLOAD;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = DP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= '0;
         part_ff      <= '0;
         sel_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         part_ff      <= part_in;
         sel_ff       <= sel_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // checks
   `SGR_ASSERT_NEXT(a_last_stops_intake, clock, reset, accept && req_last, !req_ready)
   `SGR_ASSERT_NEXT(a_ill_skips_divide, clock, reset, state_ff == ST_CHECK && status.ill_posed, state_ff == ST_EMIT)
   `SGR_ASSERT_IMPL(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_EMIT)
   `SGR_ASSERT_NEXT(a_divide_runs, clock, reset, state_ff == ST_DSTEP && step_ff != STEP_MAX, state_ff == ST_DSTEP)

endmodule

FILE: tb/tb_sgr_projection_solver_top.sv
// ----------------------------------------------------------------------------
// tb_sgr_projection_solver_top
// Self-checking bench for the projection solver: pixel units go in, every
// solve result is compared with an exact integer prediction of the weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sgr_projection_solver_top;
   import sgr_pkg::*;

   typedef struct {
      logic signed [WEIGHT_W-1:0] weight0;
      logic signed [WEIGHT_W-1:0] weight1;
      logic                       ill_posed;
   } solve_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sgr_req_if req_bus();
   sgr_rsp_if rsp_bus();
   sgr_csr_if csr_bus();

   sgr_projection_solver_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #1 clock = ~clock;

   // predictor state
   logic                     pred_en0, pred_en1;
   logic signed [SUM_W-1:0]  acc_f0_sq, acc_f1_sq, acc_f0_f1, acc_f0_err, acc_f1_err;
   logic [COUNT_W-1:0]       acc_count;
   solve_result_type         pending_weights[$];

   int  fail_count   = 0;
   bit  sender_idles = 1'b1;
   bit  sink_idles   = 1'b1;
   int  sink_holdoff = 0;

   // true when den * 1e8 < bound, or den negative
   function automatic bit is_ill(logic signed [WIDE_W-1:0] den, logic [63:0] bound);
      logic [WIDE_W-1:0] scaled;
      if (den < 0) return 1'b1;
      if (den >= (128'sd1 <<< 32)) return 1'b0;
      scaled = den * 128'd100000000;
      return scaled < {64'd0, bound};
   endfunction

   // num * 2^PRJ_SHIFT / den, rounded half to even, saturated to 32 bits
   function automatic logic [WEIGHT_W-1:0] quant_weight(logic signed [WIDE_W-1:0] num,
                                                        logic signed [WIDE_W-1:0] den);
      logic [WIDE_W-1:0] mag, q, r, twice_r, uden;
      bit neg;
      neg  = num < 0;
      mag  = neg ? -num : num;
      mag  = mag << PRJ_SHIFT;
      uden = den;
      q = mag / uden;
      r = mag % uden;
      twice_r = r << 1;
      if (twice_r > uden || (twice_r == uden && q[0])) q = q + 1;
      if (!neg) return (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
      if (q > 128'h80000000) return 32'h80000000;
      return -q[31:0];
   endfunction

   function automatic void clear_sums();
      acc_f0_sq = '0; acc_f1_sq = '0; acc_f0_f1 = '0;
      acc_f0_err = '0; acc_f1_err = '0; acc_count = '0;
   endfunction

   // fold one accepted pixel into the sums, solve on the last one
   function automatic void accept_pixel(logic [SAMPLE_W-1:0] src, logic [SAMPLE_W-1:0] deg,
                                        logic signed [FILT_W-1:0] f0,
                                        logic signed [FILT_W-1:0] f1, logic last);
      logic signed [SUM_W-1:0]  base, err, d0, d1;
      logic signed [WIDE_W-1:0] det, num0, num1;
      logic [63:0]              n;
      solve_result_type         res;
      base = SUM_W'(deg) <<< RST_SHIFT;
      err  = (SUM_W'(src) <<< RST_SHIFT) - base;
      d0   = pred_en0 ? SUM_W'(f0) - base : '0;
      d1   = pred_en1 ? SUM_W'(f1) - base : '0;
      if (acc_count < (1 << MAX_PIXELS_LOG2)) begin
         acc_f0_sq  += d0 * d0;
         acc_f1_sq  += d1 * d1;
         acc_f0_f1  += d0 * d1;
         acc_f0_err += d0 * err;
         acc_f1_err += d1 * err;
         acc_count  += COUNT_W'(1);
      end
      if (!last) return;
      res = '{'0, '0, 1'b0};
      n = 64'(acc_count);
      if (!pred_en0) begin
         if (is_ill(WIDE_W'(acc_f1_sq), n)) res.ill_posed = 1'b1;
         else res.weight1 = quant_weight(WIDE_W'(acc_f1_err), WIDE_W'(acc_f1_sq));
      end else if (!pred_en1) begin
         if (is_ill(WIDE_W'(acc_f0_sq), n)) res.ill_posed = 1'b1;
         else res.weight0 = quant_weight(WIDE_W'(acc_f0_err), WIDE_W'(acc_f0_sq));
      end else begin
         det = WIDE_W'(acc_f0_sq) * WIDE_W'(acc_f1_sq) - WIDE_W'(acc_f0_f1) * WIDE_W'(acc_f0_f1);
         if (is_ill(det, n * n)) res.ill_posed = 1'b1;
         else begin
            num0 = WIDE_W'(acc_f1_sq) * WIDE_W'(acc_f0_err)
                 - WIDE_W'(acc_f0_f1) * WIDE_W'(acc_f1_err);
            num1 = WIDE_W'(acc_f0_sq) * WIDE_W'(acc_f1_err)
                 - WIDE_W'(acc_f0_f1) * WIDE_W'(acc_f0_err);
            res.weight0 = quant_weight(num0, det);
            res.weight1 = quant_weight(num1, det);
         end
      end
      pending_weights.push_back(res);
      clear_sums();
   endfunction

   // result checker
   always @(posedge clock) begin
      solve_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_weights.size() == 0) begin
            $error("unexpected result transaction");
            fail_count++;
         end else begin
            want = pending_weights.pop_front();
            if (rsp_bus.weight0 !== want.weight0) begin
               $error("weight0 expected %0d actual %0d", want.weight0, rsp_bus.weight0);
               fail_count++;
            end
            if (rsp_bus.weight1 !== want.weight1) begin
               $error("weight1 expected %0d actual %0d", want.weight1, rsp_bus.weight1);
               fail_count++;
            end
            if (rsp_bus.ill_posed !== want.ill_posed) begin
               $error("ill_posed expected %0d actual %0d", want.ill_posed, rsp_bus.ill_posed);
               fail_count++;
            end
         end
      end
   end

   // result sink ready, with random idling and long hold-offs
   always @(negedge clock) begin
      if (sink_holdoff > 0) begin
         rsp_bus.ready = 1'b0;
         sink_holdoff--;
      end else if (!sink_idles) rsp_bus.ready = 1'b1;
      else rsp_bus.ready = ($urandom % 100) >= 27;
   end

   // send one pixel transaction and predict it on acceptance
   task automatic send_pixel(logic [SAMPLE_W-1:0] src, logic [SAMPLE_W-1:0] deg,
                             logic signed [FILT_W-1:0] f0, logic signed [FILT_W-1:0] f1,
                             logic last);
      @(negedge clock);
      while (sender_idles && ($urandom % 100) < 27) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.source_sample   = src;
      req_bus.degraded_sample = deg;
      req_bus.filter0_value   = f0;
      req_bus.filter1_value   = f1;
      req_bus.last_pixel      = last;
      req_bus.valid           = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      accept_pixel(src, deg, f0, f1, last);
   endtask

   // stop sending, wait for every result, then let the solver settle
   task automatic drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_weights.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic value);
      @(negedge clock);
      csr_bus.index = idx;
      csr_bus.data  = value;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      if (idx == CSR_FILTER0_EN) pred_en0 = value;
      else if (idx == CSR_FILTER1_EN) pred_en1 = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic set_filters(logic en0, logic en1);
      write_reg(CSR_FILTER0_EN, en0);
      write_reg(CSR_FILTER1_EN, en1);
   endtask

   // filter value close to the scaled degraded sample
   function automatic logic signed [FILT_W-1:0] near_base(logic [SAMPLE_W-1:0] deg, int spread);
      int v;
      v = (int'(deg) << RST_SHIFT) + $urandom_range(0, 2 * spread) - spread;
      if (v > 131071) v = 131071;
      if (v < -131072) v = -131072;
      return FILT_W'(v);
   endfunction

   task automatic random_unit(int len);
      logic [SAMPLE_W-1:0] deg;
      int spread;
      spread = 1 << $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
         deg = SAMPLE_W'($urandom);
         if (($urandom % 100) < 75)
            send_pixel(SAMPLE_W'($urandom), deg, near_base(deg, spread),
                       near_base(deg, spread), i == len - 1);
         else
            send_pixel(SAMPLE_W'($urandom), SAMPLE_W'($urandom), FILT_W'($urandom),
                       FILT_W'($urandom), i == len - 1);
      end
   endtask

   // field extremes with the default configuration
   task automatic test_extremes();
      send_pixel(12'd0, 12'd0, 18'sd0, 18'sd0, 1'b1);
      send_pixel(12'd4095, 12'd0, 18'sd131071, -18'sd131072, 1'b0);
      send_pixel(12'd0, 12'd4095, -18'sd131072, 18'sd131071, 1'b0);
      send_pixel(12'd4095, 12'd4095, 18'sd131071, 18'sd131071, 1'b0);
      send_pixel(12'd2048, 12'd1, -18'sd1, 18'sd5, 1'b1);
      send_pixel(12'd4095, 12'd0, 18'sd131071, 18'sd0, 1'b1);
      drain();
   endtask

   // zero residual filters and a fully disabled projection
   task automatic test_ill_posed();
      send_pixel(12'd100, 12'd10, 18'sd160, 18'sd160, 1'b0);
      send_pixel(12'd300, 12'd20, 18'sd320, 18'sd320, 1'b1);
      drain();
      set_filters(1'b0, 1'b0);
      send_pixel(12'd500, 12'd7, 18'sd9000, -18'sd400, 1'b1);
      drain();
      set_filters(1'b1, 1'b1);
   endtask

   // nearly collinear filters with a unit determinant saturate both ways
   task automatic test_saturation();
      send_pixel(12'd4095, 12'd0, 18'sd100000, 18'sd100001, 1'b0);
      send_pixel(12'd0, 12'd0, 18'sd100001, 18'sd100002, 1'b1);
      send_pixel(12'd4095, 12'd0, -18'sd100000, -18'sd100001, 1'b0);
      send_pixel(12'd0, 12'd0, -18'sd100001, -18'sd100002, 1'b1);
      drain();
   endtask

   // both one-filter solve modes, enables flipped between units
   task automatic test_filter_modes();
      set_filters(1'b0, 1'b1);
      random_unit(5);
      drain();
      set_filters(1'b1, 1'b0);
      random_unit(5);
      send_pixel(12'd4095, 12'd0, 18'sd1, 18'sd0, 1'b1);
      drain();
      set_filters(1'b1, 1'b1);
   endtask

   // result side stalls for a long stretch while pixels keep coming
   task automatic test_backpressure();
      sender_idles = 1'b0;
      sink_holdoff = 3000;
      for (int u = 0; u < 6; u++) random_unit(3);
      drain();
      sender_idles = 1'b1;
   endtask

   // random units under random configurations, one stretch with no idling
   task automatic test_random();
      for (int phase = 0; phase < 8; phase++) begin
         set_filters(($urandom % 4) != 0, ($urandom % 4) != 0);
         sender_idles = (phase != 3);
         sink_idles   = (phase != 3);
         for (int k = 0; k < 180; ) begin
            int len;
            len = (($urandom % 10) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
            random_unit(len);
            k += len;
         end
         drain();
      end
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.source_sample = '0;
      req_bus.degraded_sample = '0;
      req_bus.filter0_value = '0;
      req_bus.filter1_value = '0;
      req_bus.last_pixel = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_FILTER0_EN;
      csr_bus.data  = 1'b0;
      pred_en0 = 1'b1;
      pred_en1 = 1'b1;
      clear_sums();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_ill_posed();
      test_saturation();
      test_filter_modes();
      test_backpressure();
      test_random();

      if (fail_count == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog
   initial begin
      #6000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sgr_projection_solver_top.f
+incdir+rtl
rtl/sgr_pkg.sv
rtl/sgr_if.sv
rtl/sgr_dpath.sv
rtl/sgr_ctrl.sv
rtl/sgr_projection_solver_top.sv
tb/tb_sgr_projection_solver_top.sv
